// ===== hw/rtl/kgb_pkg.sv =====
// ----------------------------------------------------------------------------
// kgb_pkg
// Shared types and constants for the keypoint grid bucketing unit: word
// layouts, configuration registers, operation codes and cell store commands.
// ----------------------------------------------------------------------------
`default_nettype none

package kgb_pkg;

  // grid geometry
  localparam int unsigned MAX_COLS = 8;
  localparam int unsigned MAX_ROWS = 8;
  localparam int unsigned NCELLS   = MAX_COLS * MAX_ROWS;
  localparam int unsigned CELL_IW  = 6;

  // datapath widths
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned FRAC_W   = 12;
  localparam int unsigned PROD_W   = COORD_W + SCALE_W;
  localparam int unsigned POS_W    = PROD_W - FRAC_W + 2;
  localparam int unsigned DIV_W    = 12;
  localparam int unsigned DIV_CNT_W = 4;
  localparam int unsigned GRID_W   = 4;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_X      = 3'd0,
    CFG_SCALE_Y      = 3'd1,
    CFG_OFFSET_X     = 3'd2,
    CFG_OFFSET_Y     = 3'd3,
    CFG_BLOCK_WIDTH  = 3'd4,
    CFG_BLOCK_HEIGHT = 3'd5,
    CFG_GRID_COLS    = 3'd6,
    CFG_GRID_ROWS    = 3'd7
  } kgb_cfg_idx_e;

  typedef enum logic [2:0] {
    OP_INSERT    = 3'd0,
    OP_SET_MASK  = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_FILL_MASK = 3'd3,
    OP_EXTRACT   = 3'd4,
    OP_RESET_ALL = 3'd5
  } kgb_op_e;

  typedef struct packed {
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
    logic [15:0]        offset_x;
    logic [15:0]        offset_y;
    logic [DIV_W-1:0]   block_width;
    logic [DIV_W-1:0]   block_height;
    logic [GRID_W-1:0]  grid_cols;
    logic [GRID_W-1:0]  grid_rows;
  } kgb_cfg_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [15:0]        strength;
    logic               flag_value;
  } kgb_in_t;

  typedef struct packed {
    logic [15:0]        out_x;
    logic [15:0]        out_y;
    logic [15:0]        out_strength;
    logic [CELL_IW-1:0] cell_index;
    logic               found;
    logic               last;
  } kgb_out_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] strength;
  } kgb_cell_t;

  typedef struct packed {
    logic               clear_grid;
    logic               fill_mask;
    logic               fill_val;
    logic               mask_we;
    logic               mask_val;
    logic               rd_en;
    logic               wr_en;
    logic [CELL_IW-1:0] idx;
    kgb_cell_t          wdata;
  } kgb_cell_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kgb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// kgb_cfg_regs
// Configuration register file: transform factors, block size and grid size.
// ----------------------------------------------------------------------------
`default_nettype none

module kgb_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [kgb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [kgb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output kgb_pkg::kgb_cfg_t                     cfg_o
);

  kgb_pkg::kgb_cfg_t cfg_q;

  // register writes, reset to unit scale, no offset, 64 pixel blocks, 8x8 grid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale_x      <= 16'd4096;
      cfg_q.scale_y      <= 16'd4096;
      cfg_q.offset_x     <= '0;
      cfg_q.offset_y     <= '0;
      cfg_q.block_width  <= 12'd64;
      cfg_q.block_height <= 12'd64;
      cfg_q.grid_cols    <= 4'd8;
      cfg_q.grid_rows    <= 4'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kgb_pkg::CFG_SCALE_X:      cfg_q.scale_x      <= cfg_data_i;
        kgb_pkg::CFG_SCALE_Y:      cfg_q.scale_y      <= cfg_data_i;
        kgb_pkg::CFG_OFFSET_X:     cfg_q.offset_x     <= cfg_data_i;
        kgb_pkg::CFG_OFFSET_Y:     cfg_q.offset_y     <= cfg_data_i;
        kgb_pkg::CFG_BLOCK_WIDTH:  cfg_q.block_width  <= cfg_data_i[kgb_pkg::DIV_W-1:0];
        kgb_pkg::CFG_BLOCK_HEIGHT: cfg_q.block_height <= cfg_data_i[kgb_pkg::DIV_W-1:0];
        kgb_pkg::CFG_GRID_COLS:    cfg_q.grid_cols    <= cfg_data_i[kgb_pkg::GRID_W-1:0];
        kgb_pkg::CFG_GRID_ROWS:    cfg_q.grid_rows    <= cfg_data_i[kgb_pkg::GRID_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/kgb_div.sv =====
// ----------------------------------------------------------------------------
// kgb_div
// Restoring radix-2 divider, one quotient bit per cycle, shared by both axes.
// ----------------------------------------------------------------------------
`default_nettype none

module kgb_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [kgb_pkg::DIV_W-1:0]    dividend_i,
  input  wire logic [kgb_pkg::DIV_W-1:0]    divisor_i,
  output logic                              done_o,
  output logic [kgb_pkg::DIV_W-1:0]         quotient_o
);

  localparam int unsigned W = kgb_pkg::DIV_W;

  logic                          busy_q;
  logic                          done_q;
  logic [kgb_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [W-1:0]                  quo_q;
  logic [W-1:0]                  rem_q;
  logic [W-1:0]                  div_q;

  logic [W:0] shifted;
  logic [W:0] diff;
  logic       take;

  // trial subtract of the next partial remainder
  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign take    = (shifted >= {1'b0, div_q});

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= kgb_pkg::DIV_CNT_W'(W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[W-1:0] : shifted[W-1:0];
      quo_q <= {quo_q[W-2:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (div_q != '0)) |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/kgb_cell_store.sv =====
// ----------------------------------------------------------------------------
// kgb_cell_store
// Per-cell state: occupied and enable bits in flops, best point in a memory
// with one shared address and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kgb_cell_store (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire kgb_pkg::kgb_cell_cmd_t        cmd_i,
  output logic [kgb_pkg::NCELLS-1:0]         occ_o,
  output logic [kgb_pkg::NCELLS-1:0]         en_o,
  output kgb_pkg::kgb_cell_t                 rd_data_o
);

  logic [kgb_pkg::NCELLS-1:0] occ_q;
  logic [kgb_pkg::NCELLS-1:0] en_q;
  kgb_pkg::kgb_cell_t         mem [kgb_pkg::NCELLS];
  kgb_pkg::kgb_cell_t         rd_q;

  // occupied and enable bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      en_q  <= '1;
    end else begin
      if (cmd_i.clear_grid) begin
        occ_q <= '0;
      end else if (cmd_i.wr_en) begin
        occ_q[cmd_i.idx] <= 1'b1;
      end
      if (cmd_i.fill_mask) begin
        en_q <= {kgb_pkg::NCELLS{cmd_i.fill_val}};
      end else if (cmd_i.mask_we) begin
        en_q[cmd_i.idx] <= cmd_i.mask_val;
      end
    end
  end

  // point memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.idx] <= cmd_i.wdata;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[cmd_i.idx];
    end
  end

  assign occ_o     = occ_q;
  assign en_o      = en_q;
  assign rd_data_o = rd_q;

`ifndef SYNTHESIS
  a_no_rd_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.rd_en && cmd_i.wr_en))
    else $error("cell store read and write in the same cycle");

  a_wr_sets_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_en && !cmd_i.clear_grid) |=> occ_q[$past(cmd_i.idx)])
    else $error("cell write did not mark the cell occupied");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_grid |=> (occ_q == '0))
    else $error("grid clear left occupied cells");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/keypoint_grid_bucketing_unit.sv =====
// ----------------------------------------------------------------------------
// keypoint_grid_bucketing_unit
// Bins points into a grid of cells, keeping the strongest point per cell,
// with per-cell masking, grid clear, mask fill and ordered extraction.
// ----------------------------------------------------------------------------
// Insert steps from accept to the next accept through x multiply, y multiply,
// y offset, two 12-bit divisions on the shared divider, locate, compare and
// write, idle; set mask and skipped or masked inserts skip the compare. Clear,
// fill mask and reset all apply and go idle. Extract scans one cell per cycle
// to the last occupied one, reading out each occupied one, plus output stalls.
// One item at a time. Reset is immediate: grid empty, all cells enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module keypoint_grid_bucketing_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration write port
  input  wire logic                             cfg_we_i,
  input  wire logic [kgb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [kgb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input words
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire kgb_pkg::kgb_in_t                 in_data_i,
  // result words
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output kgb_pkg::kgb_out_t                     out_data_o
);

  localparam int unsigned NC = kgb_pkg::NCELLS;
  localparam int unsigned IW = kgb_pkg::CELL_IW;
  localparam int unsigned PW = kgb_pkg::POS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPLY,
    S_MULX,
    S_MULY,
    S_OFFY,
    S_DIVX,
    S_DIVY,
    S_LOCATE,
    S_CMP,
    S_SCAN,
    S_SREAD,
    S_OUT
  } state_e;

  kgb_pkg::kgb_cfg_t      cfg;
  kgb_pkg::kgb_cell_cmd_t cell_cmd;
  kgb_pkg::kgb_cell_t     rd_data;
  logic [NC-1:0]          occ;
  logic [NC-1:0]          cell_en;

  state_e                     state_q;
  kgb_pkg::kgb_in_t           req_q;
  kgb_pkg::kgb_out_t          out_q;
  logic                       out_valid_q;
  logic [kgb_pkg::PROD_W-1:0] prod_q;
  logic [15:0]                px_q;
  logic [15:0]                py_q;
  logic                       skip_q;
  logic [kgb_pkg::DIV_W-1:0]  col_q;
  logic [kgb_pkg::DIV_W-1:0]  row_q;
  logic [IW-1:0]              idx_q;
  logic [IW-1:0]              scan_q;

  logic [kgb_pkg::PROD_W-1:0]  prod;
  logic [kgb_pkg::COORD_W-1:0] mul_a;
  logic [kgb_pkg::SCALE_W-1:0] mul_b;
  logic [15:0]                 off;
  logic [PW-1:0]               pos;
  logic                        pos_oob;
  logic [kgb_pkg::GRID_W-1:0]  cols_sat;
  logic [kgb_pkg::GRID_W-1:0]  rows_sat;
  logic [15:0]                 idx_w;
  logic [IW-1:0]               idx;
  logic                        hit;
  logic [NC-1:0]               occ_above;
  logic                        scan_last;
  logic                        div_start;
  logic                        div_done;
  logic [kgb_pkg::DIV_W-1:0]   div_dividend;
  logic [kgb_pkg::DIV_W-1:0]   div_divisor;
  logic [kgb_pkg::DIV_W-1:0]   div_quo;

  kgb_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  kgb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  kgb_cell_store u_cells (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cell_cmd),
    .occ_o     (occ),
    .en_o      (cell_en),
    .rd_data_o (rd_data)
  );

  // shared scale multiplier, x axis first then y
  assign mul_a = (state_q == S_MULX) ? req_q.x_coord : req_q.y_coord;
  assign mul_b = (state_q == S_MULX) ? cfg.scale_x : cfg.scale_y;
  assign prod  = kgb_pkg::PROD_W'(mul_a) * kgb_pkg::PROD_W'(mul_b);

  // drop fraction bits, add signed offset, check 0..65535
  assign off     = (state_q == S_MULY) ? cfg.offset_x : cfg.offset_y;
  assign pos     = {2'b00, prod_q[kgb_pkg::PROD_W-1:kgb_pkg::FRAC_W]}
                 + {{(PW - 16){off[15]}}, off};
  assign pos_oob = pos[PW-1] | (|pos[PW-2:16]);

  // divider operands, whole pixels by block size
  assign div_start    = (state_q == S_OFFY) || ((state_q == S_DIVX) && div_done);
  assign div_dividend = (state_q == S_OFFY) ? px_q[15:4] : py_q[15:4];
  assign div_divisor  = (state_q == S_OFFY) ? cfg.block_width : cfg.block_height;

  // cell lookup with saturated grid size
  assign cols_sat = (cfg.grid_cols > kgb_pkg::GRID_W'(kgb_pkg::MAX_COLS))
                  ? kgb_pkg::GRID_W'(kgb_pkg::MAX_COLS) : cfg.grid_cols;
  assign rows_sat = (cfg.grid_rows > kgb_pkg::GRID_W'(kgb_pkg::MAX_ROWS))
                  ? kgb_pkg::GRID_W'(kgb_pkg::MAX_ROWS) : cfg.grid_rows;
  assign idx_w    = 16'(row_q) * 16'(cols_sat) + 16'(col_q);
  assign idx      = idx_w[IW-1:0];
  assign hit      = !skip_q
                 && (cfg.block_width != '0) && (cfg.block_height != '0)
                 && (col_q < kgb_pkg::DIV_W'(cols_sat))
                 && (row_q < kgb_pkg::DIV_W'(rows_sat));

  // no occupied cell beyond the scan position
  assign occ_above = occ >> scan_q;
  assign scan_last = ~|occ_above[NC-1:1];

  // cell store commands
  always_comb begin
    cell_cmd       = '0;
    cell_cmd.wdata = '{x: px_q, y: py_q, strength: req_q.strength};
    case (state_q)
      S_LOCATE: cell_cmd.idx = idx;
      S_CMP:    cell_cmd.idx = idx_q;
      default:  cell_cmd.idx = scan_q;
    endcase
    case (state_q)
      S_APPLY: begin
        cell_cmd.clear_grid = (req_q.operation == kgb_pkg::OP_CLEAR)
                           || (req_q.operation == kgb_pkg::OP_RESET_ALL);
        cell_cmd.fill_mask  = (req_q.operation == kgb_pkg::OP_FILL_MASK)
                           || (req_q.operation == kgb_pkg::OP_RESET_ALL);
        cell_cmd.fill_val   = (req_q.operation == kgb_pkg::OP_RESET_ALL)
                           || req_q.flag_value;
      end
      S_LOCATE: begin
        cell_cmd.mask_we  = hit && (req_q.operation == kgb_pkg::OP_SET_MASK);
        cell_cmd.mask_val = req_q.flag_value;
        cell_cmd.rd_en    = hit && (req_q.operation == kgb_pkg::OP_INSERT) && cell_en[idx];
      end
      S_CMP: begin
        cell_cmd.wr_en = !occ[idx_q] || (req_q.strength > rd_data.strength);
      end
      S_SCAN: begin
        cell_cmd.rd_en = occ[scan_q];
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      prod_q      <= '0;
      px_q        <= '0;
      py_q        <= '0;
      skip_q      <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      idx_q       <= '0;
      scan_q      <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q  <= in_data_i;
            skip_q <= 1'b0;
            scan_q <= '0;
            case (in_data_i.operation)
              kgb_pkg::OP_INSERT,
              kgb_pkg::OP_SET_MASK: state_q <= S_MULX;
              kgb_pkg::OP_CLEAR,
              kgb_pkg::OP_FILL_MASK,
              kgb_pkg::OP_RESET_ALL: state_q <= S_APPLY;
              kgb_pkg::OP_EXTRACT: begin
                if (occ == '0) begin
                  // empty grid gives one blank closing word
                  out_q       <= '{out_x: '0, out_y: '0, out_strength: '0,
                                   cell_index: '0, found: 1'b0, last: 1'b1};
                  out_valid_q <= 1'b1;
                  state_q     <= S_OUT;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_APPLY: state_q <= S_IDLE;
        S_MULX: begin
          prod_q  <= prod;
          state_q <= S_MULY;
        end
        S_MULY: begin
          px_q    <= pos[15:0];
          skip_q  <= pos_oob;
          prod_q  <= prod;
          state_q <= S_OFFY;
        end
        S_OFFY: begin
          py_q    <= pos[15:0];
          skip_q  <= skip_q | pos_oob;
          state_q <= S_DIVX;
        end
        S_DIVX: begin
          if (div_done) begin
            col_q   <= div_quo;
            state_q <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            row_q   <= div_quo;
            state_q <= S_LOCATE;
          end
        end
        S_LOCATE: begin
          idx_q   <= idx;
          state_q <= cell_cmd.rd_en ? S_CMP : S_IDLE;
        end
        S_CMP: state_q <= S_IDLE;
        S_SCAN: begin
          if (occ[scan_q]) begin
            state_q <= S_SREAD;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_SREAD: begin
          out_q       <= '{out_x: rd_data.x, out_y: rd_data.y,
                           out_strength: rd_data.strength, cell_index: scan_q,
                           found: 1'b1, last: scan_last};
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (out_q.last) begin
              state_q <= S_IDLE;
            end else begin
              scan_q  <= scan_q + 1'b1;
              state_q <= S_SCAN;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.operation <= kgb_pkg::OP_RESET_ALL))
    |=> !in_ready_o)
    else $error("ready after accepting a word with work to do");

  a_found_is_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.found) |-> occ[out_data_o.cell_index])
    else $error("reported cell is not occupied");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |-> (out_data_o.last && (occ == '0)))
    else $error("blank result on a non-empty grid or not last");

  a_write_enabled_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_cmd.wr_en |-> cell_en[cell_cmd.idx])
    else $error("point written into a masked cell");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keypoint grid bucketing unit. A scoreboard class
// keeps its own copy of the cell store, mask and registers, predicts the words
// every extraction returns and compares them field by field in order. Words
// come from a directed opening and then random traffic over several register
// settings, with random gaps on the input side and stalls on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kgb_pkg::*;

  // codes the block leaves unused
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_PRINTS    = 40;
  localparam int DRAIN_LIMIT   = 20000;

  // --------------------------------------------------------------------------
  // scoreboard: mirror of the grid and queue of expected result words
  // --------------------------------------------------------------------------
  class grid_scoreboard;
    logic [15:0] scale_x, scale_y, offset_x, offset_y;
    logic [11:0] block_w, block_h;
    logic [3:0]  cols_reg, rows_reg;
    bit          bin_used [NCELLS];
    bit          bin_on   [NCELLS];
    logic [15:0] bin_x    [NCELLS];
    logic [15:0] bin_y    [NCELLS];
    logic [15:0] bin_str  [NCELLS];
    kgb_out_t    expected_q[$];
    int          errors;
    int          results_seen;
    int          words_seen;
    int          inserts_seen;
    int          extracts_seen;

    function new();
      scale_x  = 16'd4096;
      scale_y  = 16'd4096;
      offset_x = '0;
      offset_y = '0;
      block_w  = 12'd64;
      block_h  = 12'd64;
      cols_reg = 4'd8;
      rows_reg = 4'd8;
      foreach (bin_used[i]) begin
        bin_used[i] = 1'b0;
        bin_on[i]   = 1'b1;
        bin_x[i]    = '0;
        bin_y[i]    = '0;
        bin_str[i]  = '0;
      end
      errors        = 0;
      results_seen  = 0;
      words_seen    = 0;
      inserts_seen  = 0;
      extracts_seen = 0;
    endfunction

    task report_error(string msg);
      if (errors < MAX_PRINTS) $display("mismatch: %s", msg);
      errors++;
    endtask

    // append one word to the expected queue
    function void add_expected(kgb_out_t w);
      expected_q = {expected_q, w};
    endfunction

    function void set_reg(kgb_cfg_idx_e idx, logic [15:0] v);
      case (idx)
        CFG_SCALE_X:      scale_x  = v;
        CFG_SCALE_Y:      scale_y  = v;
        CFG_OFFSET_X:     offset_x = v;
        CFG_OFFSET_Y:     offset_y = v;
        CFG_BLOCK_WIDTH:  block_w  = v[11:0];
        CFG_BLOCK_HEIGHT: block_h  = v[11:0];
        CFG_GRID_COLS:    cols_reg = v[3:0];
        CFG_GRID_ROWS:    rows_reg = v[3:0];
        default: ;
      endcase
    endfunction

    // transform a point and find its cell; 0 when the point is skipped
    function bit locate(kgb_in_t w, output logic [15:0] px, output logic [15:0] py,
                        output int idx);
      longint xl, yl, cols, rows, c, r;
      px  = '0;
      py  = '0;
      idx = 0;
      xl = ((longint'(w.x_coord) * longint'(scale_x)) >> 12) + longint'($signed(offset_x));
      yl = ((longint'(w.y_coord) * longint'(scale_y)) >> 12) + longint'($signed(offset_y));
      if (xl < 0 || xl > 65535 || yl < 0 || yl > 65535) return 1'b0;
      if (block_w == 0 || block_h == 0) return 1'b0;
      cols = (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
      rows = (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
      c = (xl >> 4) / longint'(block_w);
      r = (yl >> 4) / longint'(block_h);
      // a column past the grid is dropped, it never spills into the next row
      if (c >= cols || r >= rows) return 1'b0;
      idx = int'(r * cols + c);
      px  = xl[15:0];
      py  = yl[15:0];
      return 1'b1;
    endfunction

    // update the mirror for one accepted input word
    function void note_input(kgb_in_t w);
      logic [15:0] px, py;
      int          idx, last_i;
      kgb_out_t    res;
      words_seen++;
      case (w.operation)
        OP_INSERT: begin
          inserts_seen++;
          if (locate(w, px, py, idx) && bin_on[idx]) begin
            // ties keep the stored point
            if (!bin_used[idx] || w.strength > bin_str[idx]) begin
              bin_used[idx] = 1'b1;
              bin_x[idx]    = px;
              bin_y[idx]    = py;
              bin_str[idx]  = w.strength;
            end
          end
        end
        OP_SET_MASK: begin
          if (locate(w, px, py, idx)) bin_on[idx] = w.flag_value;
        end
        OP_CLEAR: begin
          foreach (bin_used[i]) bin_used[i] = 1'b0;
        end
        OP_FILL_MASK: begin
          foreach (bin_on[i]) bin_on[i] = w.flag_value;
        end
        OP_EXTRACT: begin
          extracts_seen++;
          last_i = -1;
          foreach (bin_used[i]) if (bin_used[i]) last_i = i;
          if (last_i < 0) begin
            // empty grid gives a single empty word
            res = '0;
            res.last = 1'b1;
            add_expected(res);
          end else begin
            foreach (bin_used[i]) begin
              if (bin_used[i]) begin
                res.out_x        = bin_x[i];
                res.out_y        = bin_y[i];
                res.out_strength = bin_str[i];
                res.cell_index   = CELL_IW'(i);
                res.found        = 1'b1;
                res.last         = (i == last_i);
                add_expected(res);
              end
            end
          end
        end
        OP_RESET_ALL: begin
          foreach (bin_used[i]) begin
            bin_used[i] = 1'b0;
            bin_on[i]   = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    // compare one accepted result word with the oldest expectation
    task check_result(kgb_out_t got);
      kgb_out_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_error($sformatf("result word %0d not expected: %h", results_seen, got));
        return;
      end
      want = expected_q.pop_front();
      if (got.out_x !== want.out_x)
        report_error($sformatf("word %0d out_x %h, want %h", results_seen,
                               got.out_x, want.out_x));
      if (got.out_y !== want.out_y)
        report_error($sformatf("word %0d out_y %h, want %h", results_seen,
                               got.out_y, want.out_y));
      if (got.out_strength !== want.out_strength)
        report_error($sformatf("word %0d out_strength %h, want %h", results_seen,
                               got.out_strength, want.out_strength));
      if (got.cell_index !== want.cell_index)
        report_error($sformatf("word %0d cell_index %0d, want %0d", results_seen,
                               got.cell_index, want.cell_index));
      if (got.found !== want.found)
        report_error($sformatf("word %0d found %b, want %b", results_seen,
                               got.found, want.found));
      if (got.last !== want.last)
        report_error($sformatf("word %0d last %b, want %b", results_seen,
                               got.last, want.last));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // signals and block under test
  // --------------------------------------------------------------------------
  logic         clk_i       = 1'b0;
  logic         rst_ni      = 1'b0;
  logic         cfg_we_i    = 1'b0;
  kgb_cfg_idx_e cfg_idx_i   = CFG_SCALE_X;
  logic [15:0]  cfg_data_i  = '0;
  logic         in_valid_i  = 1'b0;
  logic         in_ready_o;
  kgb_in_t      in_data_i   = '0;
  logic         out_valid_o;
  logic         out_ready_i = 1'b0;
  kgb_out_t     out_data_o;

  grid_scoreboard sb = new();
  bit             calm = 1'b0;
  int             settings_used = 0;
  kgb_cfg_t       cur_cfg;
  int             phase_words [8] = '{40, 40, 35, 45, 40, 15, 45, 40};

  always #5 clk_i = ~clk_i;

  keypoint_grid_bucketing_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // random idle decision, off during the calm stretch
  function automatic bit take_gap();
    return !calm && ($urandom_range(0, 99) < 7);
  endfunction

  // result side: check accepted words, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
    out_ready_i <= !take_gap();
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic kgb_in_t make_word(logic [2:0] op, logic [15:0] x, logic [15:0] y,
                                        logic [15:0] s, logic f);
    kgb_in_t w;
    w.operation  = op;
    w.x_coord    = x;
    w.y_coord    = y;
    w.strength   = s;
    w.flag_value = f;
    return w;
  endfunction

  // pick a raw coordinate that lands near the configured grid after the transform
  function automatic logic [15:0] aim_coord(logic [15:0] scale, logic [15:0] off,
                                            logic [11:0] blk, logic [3:0] n);
    longint cells, size, span, target, c;
    cells  = (n == 0) ? 1 : ((n > MAX_COLS) ? MAX_COLS : n);
    size   = (blk == 0) ? 64 : blk;
    span   = (cells + 1) * size * 16;
    target = longint'($urandom_range(0, int'(span)));
    if (scale == 0) return 16'($urandom);
    c = ((target - longint'($signed(off))) * 4096 + longint'(scale) - 1) / longint'(scale);
    if (c < 0) c = 0;
    else if (c > 65535) c = 65535;
    return c[15:0];
  endfunction

  function automatic kgb_in_t random_word();
    kgb_in_t w;
    int      pick;
    w = make_word(3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    // narrow strengths make ties common
    if ($urandom_range(0, 3) == 0) w.strength = 16'($urandom_range(0, 7));
    if ($urandom_range(0, 4) != 0) begin
      w.x_coord = aim_coord(cur_cfg.scale_x, cur_cfg.offset_x, cur_cfg.block_width,
                            cur_cfg.grid_cols);
      w.y_coord = aim_coord(cur_cfg.scale_y, cur_cfg.offset_y, cur_cfg.block_height,
                            cur_cfg.grid_rows);
    end
    pick = $urandom_range(0, 99);
    if (pick < 56) w.operation = OP_INSERT;
    else if (pick < 68) w.operation = OP_SET_MASK;
    else if (pick < 80) w.operation = OP_EXTRACT;
    else if (pick < 84) w.operation = OP_CLEAR;
    else if (pick < 89) begin
      w.operation  = OP_FILL_MASK;
      w.flag_value = ($urandom_range(0, 3) != 0);
    end
    else if (pick < 93) w.operation = OP_RESET_ALL;
    else w.operation = pick[0] ? OP_SPARE_HI : OP_SPARE_LO;
    return w;
  endfunction

  function automatic kgb_cfg_t settings_for(int k);
    kgb_cfg_t c;
    case (k)
      0: c = '{scale_x: 16'd4096, scale_y: 16'd4096, offset_x: 16'd0, offset_y: 16'd0,
               block_width: 12'd64, block_height: 12'd64, grid_cols: 4'd8, grid_rows: 4'd8};
      // one-pixel cells
      1: c = '{scale_x: 16'd4096, scale_y: 16'd4096, offset_x: 16'd0, offset_y: 16'd0,
               block_width: 12'd1, block_height: 12'd1, grid_cols: 4'd8, grid_rows: 4'd8};
      // extreme scales and offsets, one huge cell
      2: c = '{scale_x: 16'hFFFF, scale_y: 16'd0, offset_x: 16'h8000, offset_y: 16'h7FFF,
               block_width: 12'd4095, block_height: 12'd4095, grid_cols: 4'd1,
               grid_rows: 4'd1};
      3: c = '{scale_x: 16'd2048, scale_y: 16'd8192, offset_x: -16'sd512, offset_y: 16'd800,
               block_width: 12'd37, block_height: 12'd21, grid_cols: 4'd5, grid_rows: 4'd3};
      // oversized grid saturates
      4: c = '{scale_x: 16'd4096, scale_y: 16'd6000, offset_x: 16'd300, offset_y: -16'sd100,
               block_width: 12'd20, block_height: 12'd300, grid_cols: 4'd15,
               grid_rows: 4'd12};
      // zero block width and zero columns skip every point
      5: c = '{scale_x: 16'd4096, scale_y: 16'd4096, offset_x: 16'd0, offset_y: 16'd0,
               block_width: 12'd0, block_height: 12'd0, grid_cols: 4'd0, grid_rows: 4'd8};
      6: c = '{scale_x: 16'($urandom_range(2048, 12288)),
               scale_y: 16'($urandom_range(2048, 12288)),
               offset_x: 16'($signed($urandom_range(0, 800)) - 400),
               offset_y: 16'($signed($urandom_range(0, 800)) - 400),
               block_width: 12'($urandom_range(1, 150)),
               block_height: 12'($urandom_range(1, 150)),
               grid_cols: 4'($urandom_range(1, 8)), grid_rows: 4'($urandom_range(1, 8))};
      default: c = '{scale_x: 16'($urandom), scale_y: 16'($urandom),
                     offset_x: 16'($urandom), offset_y: 16'($urandom),
                     block_width: 12'($urandom), block_height: 12'($urandom),
                     grid_cols: 4'($urandom), grid_rows: 4'($urandom)};
    endcase
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // driving tasks
  // --------------------------------------------------------------------------
  // present one input word and hold it until it is taken
  task automatic send_word(kgb_in_t w);
    if (take_gap()) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (take_gap());
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(w);
  endtask

  // wait for every expected word, then let any insert in flight finish
  task automatic settle();
    int n;
    in_valid_i <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && sb.expected_q.size() != 0; n++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(kgb_cfg_t c);
    kgb_cfg_idx_e idx;
    logic [15:0]  val;
    cur_cfg = c;
    settings_used++;
    idx = idx.first();
    repeat (idx.num()) begin
      case (idx)
        CFG_SCALE_X:      val = c.scale_x;
        CFG_SCALE_Y:      val = c.scale_y;
        CFG_OFFSET_X:     val = c.offset_x;
        CFG_OFFSET_Y:     val = c.offset_y;
        CFG_BLOCK_WIDTH:  val = 16'(c.block_width);
        CFG_BLOCK_HEIGHT: val = 16'(c.block_height);
        CFG_GRID_COLS:    val = 16'(c.grid_cols);
        default:          val = 16'(c.grid_rows);
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= val;
      @(posedge clk_i);
      sb.set_reg(idx, val);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
  endtask

  // opening sequence at reset settings: 64-pixel cells, 8 x 8 grid
  task automatic run_directed();
    send_word(make_word(OP_EXTRACT,   16'd0,     16'd0,     16'd0,     1'b0));
    send_word(make_word(OP_INSERT,    16'd0,     16'd0,     16'd100,   1'b0));
    send_word(make_word(OP_INSERT,    16'd16,    16'd0,     16'd100,   1'b1));
    send_word(make_word(OP_INSERT,    16'd32,    16'd0,     16'd101,   1'b0));
    send_word(make_word(OP_INSERT,    16'd8176,  16'd8176,  16'd0,     1'b0));
    send_word(make_word(OP_INSERT,    16'd8192,  16'd0,     16'd555,   1'b0));
    send_word(make_word(OP_INSERT,    16'hFFFF,  16'hFFFF,  16'd9,     1'b1));
    send_word(make_word(OP_SET_MASK,  16'd1024,  16'd1024,  16'd0,     1'b0));
    send_word(make_word(OP_INSERT,    16'd1024,  16'd1040,  16'd500,   1'b0));
    send_word(make_word(OP_SET_MASK,  16'hFFFF,  16'd1024,  16'hFFFF,  1'b0));
    send_word(make_word(OP_SET_MASK,  16'd1100,  16'd1100,  16'd0,     1'b1));
    send_word(make_word(OP_INSERT,    16'd1030,  16'd1030,  16'hFFFF,  1'b0));
    send_word(make_word(OP_INSERT,    16'd1024,  16'd0,     16'hFFFF,  1'b0));
    send_word(make_word(OP_SPARE_LO,  16'hA5A5,  16'h5A5A,  16'h1234,  1'b1));
    send_word(make_word(OP_SPARE_HI,  16'h5A5A,  16'hA5A5,  16'hEDCB,  1'b0));
    send_word(make_word(OP_EXTRACT,   16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1));
    send_word(make_word(OP_FILL_MASK, 16'd0,     16'd0,     16'd0,     1'b0));
    send_word(make_word(OP_INSERT,    16'd2048,  16'd0,     16'd7,     1'b0));
    send_word(make_word(OP_FILL_MASK, 16'd0,     16'd0,     16'd0,     1'b1));
    send_word(make_word(OP_CLEAR,     16'd0,     16'd0,     16'd0,     1'b0));
    send_word(make_word(OP_EXTRACT,   16'd0,     16'd0,     16'd0,     1'b0));
    send_word(make_word(OP_INSERT,    16'd3000,  16'd3000,  16'd42,    1'b0));
    send_word(make_word(OP_RESET_ALL, 16'd0,     16'd0,     16'd0,     1'b0));
    send_word(make_word(OP_EXTRACT,   16'd0,     16'd0,     16'd0,     1'b0));
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    for (int k = 0; k < 8; k++) begin
      settle();
      apply_settings(settings_for(k));
      // phase with one-pixel cells runs without any idling
      calm = (k == 1);
      repeat (phase_words[k]) send_word(random_word());
    end
    calm = 1'b0;

    settle();
    if (sb.expected_q.size() != 0)
      sb.report_error($sformatf("%0d expected words never arrived", sb.expected_q.size()));

    $display("covered %0d input words (%0d inserts, %0d extracts) over %0d register settings",
             sb.words_seen, sb.inserts_seen, sb.extracts_seen, settings_used);
    $display("checked %0d result words, %0d errors", sb.results_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/kgb_pkg.sv
hw/rtl/kgb_cfg_regs.sv
hw/rtl/kgb_div.sv
hw/rtl/kgb_cell_store.sv
hw/rtl/keypoint_grid_bucketing_unit.sv
dv/tb.sv
